[rtl/core/asf_pkg.sv]
// ============================================================================
// asf_pkg: shared types and constants of the five-tap smoothing filter
// Sample and sum types, the binomial weights, the filter mode codes and the
// control groups that pass between the window cells and the filter datapath.
// ============================================================================
package asf_pkg;

    // Window length and the sample format.
    localparam int TAPS      = 5;
    localparam int HIST      = TAPS - 1;
    localparam int SAMPLE_W  = 8;
    localparam int SUM_W     = 12;
    localparam int CENTRE    = 2;

    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Zero level of the offset-binary samples.
    localparam sample_t SILENCE = 8'd128;

    // Filter mode codes.
    localparam logic MODE_MEAN  = 1'b0;
    localparam logic MODE_GAUSS = 1'b1;

    // Binomial weights 1, 4, 6, 4, 1 (sixteenths), tap 0 is the oldest.
    localparam logic [TAPS-1:0][2:0] BINOM_W = {3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

    // Division by five as a multiply by 205 / 1024, exact for magnitudes
    // up to 640, and division by sixteen as a shift.
    localparam logic [7:0] MEAN_RECIP  = 8'd205;
    localparam int         MEAN_SHIFT  = 10;
    localparam int         GAUSS_SHIFT = 4;

    // Control of the window cells for one cycle.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // One window handed to the filter datapath.
    typedef struct packed {
        logic                          valid;
        logic                          last;
        logic                          mode;
        logic [TAPS-1:0][SAMPLE_W-1:0] taps;
    } dp_in_t;

endpackage

[rtl/core/asf_if.sv]
// ============================================================================
// asf_if: valid/ready channels of the five-tap smoothing filter
// Input sample channel, filtered result channel and configuration write
// channel, each with a source and a sink side.
// ============================================================================

// Input samples.
interface asf_in_if;
    logic            valid;
    logic            ready;
    asf_pkg::sample_t sample;
    logic            last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// Filtered results.
interface asf_out_if;
    logic            valid;
    logic            ready;
    asf_pkg::sample_t smoothed;
    logic            last_out;

    modport source (output valid, output smoothed, output last_out, input ready);
    modport sink   (input valid, input smoothed, input last_out, output ready);
endinterface

// Configuration writes of the filter mode register.
interface asf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/asf_cell.sv]
// ============================================================================
// asf_cell: one position of the sample window
// Holds one sample and a flag that marks it as part of the current stream.
// Takes its neighbor's contents on a shift and returns to silence on a clear.
// ============================================================================
module asf_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  asf_pkg::cell_ctl_t  ctl,
    input  asf_pkg::sample_t    shift_sample,
    input  logic                shift_live,
    output asf_pkg::sample_t    sample,
    output logic                live
);

    asf_pkg::sample_t sample_reg;
    asf_pkg::sample_t sample_next;
    logic             live_reg;
    logic             live_next;

    // Clear has priority over a shift.
    always_comb
    begin
        sample_next = sample_reg;
        live_next   = live_reg;
        if (ctl.clear)
        begin
            sample_next = asf_pkg::SILENCE;
            live_next   = 1'b0;
        end
        else if (ctl.shift)
        begin
            sample_next = shift_sample;
            live_next   = shift_live;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= asf_pkg::SILENCE;
            live_reg   <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            live_reg   <= live_next;
        end
    end

    assign sample = sample_reg;
    assign live   = live_reg;

endmodule

[rtl/core/asf_datapath.sv]
// ============================================================================
// asf_datapath: sum, scale and clip stages of the smoothing filter
// Stage one forms the plain or binomially weighted sum of the five taps.
// Stage two divides toward zero, restores the zero level, clips and holds
// the result for the output channel.
// ============================================================================
module asf_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  asf_pkg::dp_in_t  win,
    output logic             take,
    asf_out_if.source        results
);

    localparam int MAG_W  = asf_pkg::SUM_W;
    localparam int PROD_W = 10 + 8;
    localparam int Q_W    = 8;
    localparam int VAL_W  = 10;

    // Stage one registers.
    logic             sum_valid_reg;
    logic             sum_valid_next;
    asf_pkg::sum_t    sum_reg;
    asf_pkg::sum_t    sum_next;
    logic             sum_mode_reg;
    logic             sum_last_reg;

    // Output registers.
    logic             out_valid_reg;
    logic             out_valid_next;
    asf_pkg::sample_t out_sample_reg;
    asf_pkg::sample_t out_sample_next;
    logic             out_last_reg;

    logic             en_out;
    logic             en_sum;

    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [Q_W-1:0]          quot;
    logic signed [VAL_W-1:0] sval;
    logic signed [VAL_W-1:0] level;

    // Each stage moves when it is empty or its contents move on.
    assign en_out = !out_valid_reg || results.ready;
    assign en_sum = !sum_valid_reg || en_out;
    assign take   = en_sum;

    // Sum of the centred deviations, weighted in Gaussian mode.
    always_comb
    begin
        asf_pkg::sum_t dev;
        sum_next = '0;
        for (int k = 0; k < asf_pkg::TAPS; k++)
        begin
            dev = asf_pkg::sum_t'({1'b0, win.taps[k]}) -
                  asf_pkg::sum_t'({1'b0, asf_pkg::SILENCE});
            if (win.mode == asf_pkg::MODE_GAUSS)
                sum_next = sum_next + dev * asf_pkg::sum_t'(asf_pkg::BINOM_W[k]);
            else
                sum_next = sum_next + dev;
        end
    end

    assign sum_valid_next = en_sum ? win.valid : sum_valid_reg;

    // Divide the magnitude, put the sign back, add the zero level and clip.
    always_comb
    begin
        mag  = sum_reg[asf_pkg::SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
        prod = PROD_W'(mag[9:0]) * PROD_W'(asf_pkg::MEAN_RECIP);
        if (sum_mode_reg == asf_pkg::MODE_GAUSS)
            quot = mag[asf_pkg::GAUSS_SHIFT +: Q_W];
        else
            quot = prod[asf_pkg::MEAN_SHIFT +: Q_W];
        sval  = sum_reg[asf_pkg::SUM_W-1] ? -VAL_W'(quot) : VAL_W'(quot);
        level = sval + VAL_W'(asf_pkg::SILENCE);
        if (level < 0)
            out_sample_next = '0;
        else if (level > VAL_W'(255))
            out_sample_next = '1;
        else
            out_sample_next = level[asf_pkg::SAMPLE_W-1:0];
    end

    assign out_valid_next = en_out ? sum_valid_reg : out_valid_reg;

    // Control state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            sum_reg      <= sum_next;
            sum_mode_reg <= win.mode;
            sum_last_reg <= win.last;
        end
        if (en_out)
        begin
            out_sample_reg <= out_sample_next;
            out_last_reg   <= sum_last_reg;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.smoothed = out_sample_reg;
    assign results.last_out = out_last_reg;

endmodule

[rtl/core/audio_smoothing_fir_5tap.sv]
// ============================================================================
// audio_smoothing_fir_5tap: five-tap mean or binomial audio smoothing filter
// A row of window cells shifts one sample per transfer; each step feeds the
// sum and scale stages, which give one result per centred sample.
// ============================================================================
//
//  channel   side   payload                   transfer
//  -------   ----   -----------------------   ------------------------------
//  samples   sink   sample[7:0], last         samples.valid && samples.ready
//  results   src    smoothed[7:0], last_out   results.valid && results.ready
//  cfg       sink   data (filter mode)        cfg.valid && cfg.ready
//
//  One sample is taken per cycle unless a flush or a stall holds the input;
//  results leave through the sum and output registers. A sample marked last
//  is followed by two flush steps of silence, while samples.ready is low.
//  Reset fills the window with silence and selects the mean filter.
//  A stall on results fills the two datapath stages and then holds the window.
//
module audio_smoothing_fir_5tap
(
    input  logic       clk,
    input  logic       rst_n,
    asf_in_if.sink     samples,
    asf_out_if.source  results,
    asf_cfg_if.sink    cfg
);

    logic                 mode_reg;
    logic                 mode_next;
    logic [1:0]           flush_reg;
    logic [1:0]           flush_next;

    logic                 take;
    logic                 accept;
    logic                 flush_step;
    logic                 final_step;
    logic                 step;
    asf_pkg::sample_t     feed_sample;
    logic                 feed_live;
    asf_pkg::cell_ctl_t   ctl;
    asf_pkg::dp_in_t      win;

    asf_pkg::sample_t     cell_sample [asf_pkg::HIST];
    logic                 cell_live   [asf_pkg::HIST];

    // Filter mode register, always ready for a write.
    assign cfg.ready = 1'b1;
    assign mode_next = (cfg.valid && cfg.ready) ? cfg.data : mode_reg;

    // Step control: a new sample or one of the two flush steps after a last.
    assign samples.ready = (flush_reg == 2'd0) && take;
    assign accept        = samples.valid && samples.ready;
    assign flush_step    = (flush_reg != 2'd0) && take;
    assign final_step    = flush_step && (flush_reg == 2'd1);
    assign step          = accept || flush_step;
    assign feed_sample   = accept ? samples.sample : asf_pkg::SILENCE;
    assign feed_live     = accept;

    always_comb
    begin
        flush_next = flush_reg;
        if (accept && samples.last)
            flush_next = 2'd2;
        else if (flush_step)
            flush_next = flush_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= asf_pkg::MODE_MEAN;
            flush_reg <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            flush_reg <= flush_next;
        end
    end

    // The window empties back to silence after the final flush step.
    assign ctl.shift = step;
    assign ctl.clear = final_step;

    // Row of window cells, oldest at index zero, fed from the top.
    for (genvar i = 0; i < asf_pkg::HIST; i++)
    begin : g_cell
        asf_pkg::sample_t nbr_sample;
        logic             nbr_live;

        if (i == asf_pkg::HIST - 1)
        begin : g_top
            assign nbr_sample = feed_sample;
            assign nbr_live   = feed_live;
        end
        else
        begin : g_mid
            assign nbr_sample = cell_sample[i+1];
            assign nbr_live   = cell_live[i+1];
        end

        asf_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .shift_sample (nbr_sample),
            .shift_live   (nbr_live),
            .sample       (cell_sample[i]),
            .live         (cell_live[i])
        );
    end

    // A step gives a result when the centre of its window is a stream sample.
    always_comb
    begin
        win.valid = step && cell_live[asf_pkg::CENTRE];
        win.last  = final_step;
        win.mode  = mode_reg;
        for (int k = 0; k < asf_pkg::HIST; k++)
            win.taps[k] = cell_sample[k];
        win.taps[asf_pkg::HIST] = feed_sample;
    end

    asf_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .win     (win),
        .take    (take),
        .results (results)
    );

endmodule

[rtl/core/asf_checker.sv]
// ============================================================================
// asf_port_checker: port checks of the five-tap smoothing filter
// Watches the sample and result channels of the top level and is bound to
// it below.
// ============================================================================
module asf_port_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_last,
    input logic             out_valid,
    input logic             out_ready,
    input asf_pkg::sample_t out_smoothed,
    input logic             out_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_smoothed) && $stable(out_last))
        else $error("result changed while stalled");

    // The flush after a last sample blocks new samples in the next cycle.
    a_flush_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("sample taken during flush");

endmodule

bind audio_smoothing_fir_5tap asf_port_checker u_asf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_last      (samples.last),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_smoothed (results.smoothed),
    .out_last     (results.last_out)
);

[sim/asf_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// asf_checker: result predictor and scoreboard for the smoothing filter
// Follows sample, result and mode-register transfers on the filter channels.
// Keeps its own copy of the window and the mode. Predicts the smoothed
// results of each sample and compares every result transfer, field by field,
// with the oldest prediction still due.
// ============================================================================
module asf_checker
(
    input  logic clk,
    input  logic rst_n,
    asf_in_if    samples,
    asf_out_if   results,
    asf_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output int   checked
);

    // The binomial weights are symmetric, so the tap order does not matter.
    localparam logic [asf_pkg::TAPS-1:0][3:0] TAP_WEIGHT =
        {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

    typedef struct packed {
        asf_pkg::sample_t smoothed;
        logic             last_out;
    } filt_result_t;

    // Four previous samples of the open stream, index 0 is the oldest.
    logic [asf_pkg::HIST-1:0][asf_pkg::SAMPLE_W-1:0] hist;
    int                                              seen;
    logic                                            mode;
    filt_result_t                                    due_results[$];

    // Smoothed value of the five samples that start at position first.
    function automatic asf_pkg::sample_t smooth_at(
        logic [asf_pkg::HIST+2:0][asf_pkg::SAMPLE_W-1:0] seq,
        int first, logic m);
        int acc;
        int dev;
        acc = 0;
        for (int k = 0; k < asf_pkg::TAPS; k++)
        begin
            dev = int'(seq[first + k]) - int'(asf_pkg::SILENCE);
            acc += (m == asf_pkg::MODE_GAUSS) ? dev * int'(TAP_WEIGHT[k]) : dev;
        end
        // Integer division truncates toward zero, as the filter does.
        acc = (m == asf_pkg::MODE_GAUSS) ? acc / 16 : acc / 5;
        acc += int'(asf_pkg::SILENCE);
        if (acc < 0)
            acc = 0;
        else if (acc > 255)
            acc = 255;
        return asf_pkg::sample_t'(acc);
    endfunction

    // Print one mismatch line (the first few only) and count it.
    task automatic report(input string what);
        if (errors < 40)
            $display("ERROR at %0t ns: %s", $time, what);
        errors++;
    endtask

    // Track transfers, predict on samples, check on results.
    always @(posedge clk or negedge rst_n)
    begin : track
        logic [asf_pkg::HIST+2:0][asf_pkg::SAMPLE_W-1:0] seq;
        filt_result_t                                    got;
        filt_result_t                                    want;
        int                                              start_pos;
        if (!rst_n)
        begin
            hist    = {asf_pkg::HIST{asf_pkg::SILENCE}};
            seen    = 0;
            mode    = asf_pkg::MODE_MEAN;
            errors  = 0;
            checked = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                for (int i = 0; i < asf_pkg::HIST; i++)
                    seq[i] = hist[i];
                seq[asf_pkg::HIST]     = samples.sample;
                seq[asf_pkg::HIST + 1] = asf_pkg::SILENCE;
                seq[asf_pkg::HIST + 2] = asf_pkg::SILENCE;
                if (samples.last)
                begin
                    // Flush every position of the stream not yet given out.
                    start_pos = (seen >= 2) ? 0 : ((seen == 1) ? 1 : 2);
                    for (int i = start_pos; i <= 2; i++)
                    begin
                        want.smoothed = smooth_at(seq, i, mode);
                        want.last_out = (i == 2);
                        due_results.push_back(want);
                    end
                    hist = {asf_pkg::HIST{asf_pkg::SILENCE}};
                    seen = 0;
                end
                else
                begin
                    // The first two samples of a stream only fill the window.
                    if (seen >= 2)
                    begin
                        want.smoothed = smooth_at(seq, 0, mode);
                        want.last_out = 1'b0;
                        due_results.push_back(want);
                    end
                    for (int i = 0; i < asf_pkg::HIST; i++)
                        hist[i] = seq[i + 1];
                    if (seen < 2)
                        seen++;
                end
            end

            if (results.valid && results.ready)
            begin
                got.smoothed = results.smoothed;
                got.last_out = results.last_out;
                checked++;
                if (due_results.size() == 0)
                    report($sformatf("result %0d (last_out %0b) with nothing expected",
                                     got.smoothed, got.last_out));
                else
                begin
                    want = due_results.pop_front();
                    if (got.smoothed !== want.smoothed)
                        report($sformatf("result %0d: smoothed %0d, expected %0d",
                                         checked, got.smoothed, want.smoothed));
                    if (got.last_out !== want.last_out)
                        report($sformatf("result %0d: last_out %0b, expected %0b",
                                         checked, got.last_out, want.last_out));
                end
            end

            // A register write only takes effect for later samples.
            if (cfg.valid && cfg.ready)
                mode = cfg.data;

            pending <= due_results.size();
        end
    end

endmodule

[sim/tb_audio_smoothing_fir_5tap.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_audio_smoothing_fir_5tap: testbench of the five-tap smoothing filter
// Drives directed and random sample streams in both filter modes, with
// random gaps on the sample side and random stalls on the result side.
// The checker beside the filter predicts and compares every result.
// ============================================================================
module tb_audio_smoothing_fir_5tap;

    logic clk;
    logic rst_n;
    logic gaps_on;
    logic stall_on;
    int   check_errors;
    int   results_due;
    int   results_checked;
    int   n_samples;
    int   n_streams;
    int   n_mode_writes;

    asf_in_if  samples_if ();
    asf_out_if results_if ();
    asf_cfg_if cfg_if ();

    audio_smoothing_fir_5tap u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    asf_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if),
        .errors  (check_errors),
        .pending (results_due),
        .checked (results_checked)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Upper bound on the run time.
    initial
    begin
        #2_000_000;
        $display("Timeout: results still outstanding");
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: ready with random stall bursts while stalls are enabled.
    initial
    begin : result_sink
        results_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                results_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                results_if.ready <= 1'b1;
            end
        end
    end

    // One sample transfer, with an occasional gap before it.
    task automatic push_sample(input asf_pkg::sample_t s, input logic lst);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            samples_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        samples_if.last   <= lst;
        do
            @(posedge clk);
        while (!samples_if.ready);
        n_samples++;
        if (lst)
            n_streams++;
    endtask

    // Let every predicted result arrive, then let the pipeline settle.
    task automatic wait_idle();
        samples_if.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the filter mode register; only called while the filter is idle.
    task automatic write_mode(input logic m);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= m;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        n_mode_writes++;
    endtask

    // Sample values weighted toward the extremes and the silence level.
    function automatic asf_pkg::sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return asf_pkg::sample_t'($urandom_range(125, 131));
            default: return asf_pkg::sample_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Random streams in one mode; an open end leaves the last stream running
    // into the next mode setting.
    task automatic random_phase(input int n_target, input logic m, input logic open_end);
        int   sent;
        int   len;
        logic closing;
        wait_idle();
        write_mode(m);
        sent = 0;
        while (sent < n_target)
        begin
            case ($urandom_range(0, 5))
                0:       len = 1;
                1:       len = 2;
                2:       len = 3;
                default: len = $urandom_range(4, 16);
            endcase
            closing = !(open_end && (sent + len >= n_target));
            for (int i = 0; i < len; i++)
                push_sample(rand_sample(), closing && (i == len - 1));
            sent += len;
        end
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        n_samples     = 0;
        n_streams     = 0;
        n_mode_writes = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        rst_n             <= 1'b0;
        samples_if.valid  <= 1'b0;
        samples_if.sample <= asf_pkg::SILENCE;
        samples_if.last   <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= asf_pkg::MODE_MEAN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mean mode: one-sample and two-sample streams, then truncation of
        // small sums on both sides of zero and full-scale swings.
        write_mode(asf_pkg::MODE_MEAN);
        push_sample(8'd255, 1'b1);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b1);
        push_sample(8'd127, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd129, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd1, 1'b0);
        push_sample(8'd254, 1'b1);

        // A stream left open across a change to the Gaussian weights.
        push_sample(8'd200, 1'b0);
        push_sample(8'd60, 1'b0);
        push_sample(8'd10, 1'b0);
        wait_idle();
        write_mode(asf_pkg::MODE_GAUSS);
        push_sample(8'd90, 1'b0);
        push_sample(8'd30, 1'b1);

        // Gaussian mode: short streams and truncation near silence.
        push_sample(8'd0, 1'b1);
        push_sample(8'd128, 1'b0);
        push_sample(8'd127, 1'b0);
        push_sample(8'd129, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b1);
        push_sample(8'd255, 1'b0);
        push_sample(8'd255, 1'b1);

        // Random streams over several mode settings.
        random_phase(70, asf_pkg::MODE_MEAN, 1'b1);
        random_phase(70, asf_pkg::MODE_GAUSS, 1'b0);
        stall_on = 1'b0;
        random_phase(70, asf_pkg::MODE_GAUSS, 1'b1);
        stall_on = 1'b1;
        random_phase(70, asf_pkg::MODE_MEAN, 1'b0);
        random_phase(70, asf_pkg::MODE_GAUSS, 1'b1);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        random_phase(70, asf_pkg::MODE_MEAN, 1'b0);

        wait_idle();
        $display("Sent %0d samples in %0d closed streams over %0d mode writes.",
                 n_samples, n_streams, n_mode_writes);
        $display("Checked %0d smoothed results in mean and Gaussian modes.",
                 results_checked);
        if (check_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
